// ----- design/brc_pkg.sv -----
// Package for the blit rectangle clipper: widths, register indexes and the per-axis clip function.
package brc_pkg;

    // Width of every coordinate, in bits.
    localparam int unsigned COORD_WIDTH = 16;

    // Number of configuration registers and the width of their index.
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [REG_IDX_W-1:0]          t_reg_idx;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEST_CLIP_MIN_X = 3'd0,
        REG_DEST_CLIP_MIN_Y = 3'd1,
        REG_DEST_CLIP_MAX_X = 3'd2,
        REG_DEST_CLIP_MAX_Y = 3'd3,
        REG_SRC_CLIP_MIN_X  = 3'd4,
        REG_SRC_CLIP_MIN_Y  = 3'd5,
        REG_SRC_CLIP_MAX_X  = 3'd6,
        REG_SRC_CLIP_MAX_Y  = 3'd7
    } t_reg_sel;

    // Reset values: minimum edges at zero, maximum edges at the largest positive coordinate.
    localparam t_coord COORD_ZERO    = '0;
    localparam t_coord COORD_MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // Outcome of clipping one axis.
    typedef struct packed {
        logic   ok;
        t_coord d;
        t_coord s0;
        t_coord s1;
    } t_axis;

    // Clip one axis: early-out tests, trim against the source clip, then against the
    // destination clip, then the emptiness test. All sums wrap to the coordinate width.
    function automatic t_axis clip_axis(
        input t_coord d,
        input t_coord s0,
        input t_coord s1,
        input t_coord sc0,
        input t_coord sc1,
        input t_coord dc0,
        input t_coord dc1
    );
        t_axis  res;
        t_coord f;
        t_coord d_a;
        t_coord f_a;
        t_coord s0_a;
        t_coord s1_a;
        t_coord s0_b;
        t_coord s1_b;
        t_coord d_b;
        logic   ok_src;
        logic   ok_dst;

        // Far corner of the destination.
        f = t_coord'(d + t_coord'(s1 - s0));

        // Early-out against both clip rectangles.
        ok_src = !((s0 > sc1) || (s1 < sc0));
        ok_dst = !((d > dc1) || (f < dc0));

        // Trim against the source clip.
        d_a  = (s0 < sc0) ? t_coord'(d + t_coord'(sc0 - s0)) : d;
        s0_a = (s0 < sc0) ? sc0 : s0;
        f_a  = (s1 > sc1) ? t_coord'(f - t_coord'(s1 - sc1)) : f;
        s1_a = (s1 > sc1) ? sc1 : s1;

        // Trim against the destination clip.
        s0_b = (d_a < dc0) ? t_coord'(s0_a + t_coord'(dc0 - d_a)) : s0_a;
        d_b  = (d_a < dc0) ? dc0 : d_a;
        s1_b = (f_a > dc1) ? t_coord'(s1_a - t_coord'(f_a - dc1)) : s1_a;

        res.ok = ok_src && ok_dst && !(s1_b < s0_b);
        res.d  = d_b;
        res.s0 = s0_b;
        res.s1 = s1_b;
        return res;
    endfunction

endpackage

// ----- design/brc_ifs.sv -----
// Channel interfaces of the blit rectangle clipper: request, result and configuration write.

// Blit request channel.
interface brc_req_if;
    logic               valid;
    logic               ready;
    brc_pkg::t_coord    dst_x;
    brc_pkg::t_coord    dst_y;
    brc_pkg::t_coord    src_min_x;
    brc_pkg::t_coord    src_min_y;
    brc_pkg::t_coord    src_max_x;
    brc_pkg::t_coord    src_max_y;

    modport source (
        output valid, dst_x, dst_y, src_min_x, src_min_y, src_max_x, src_max_y,
        input  ready
    );
    modport sink (
        input  valid, dst_x, dst_y, src_min_x, src_min_y, src_max_x, src_max_y,
        output ready
    );
endinterface

// Clipped result channel.
interface brc_res_if;
    logic               valid;
    logic               ready;
    logic               visible;
    brc_pkg::t_coord    out_dst_x;
    brc_pkg::t_coord    out_dst_y;
    brc_pkg::t_coord    out_src_min_x;
    brc_pkg::t_coord    out_src_min_y;
    brc_pkg::t_coord    out_src_max_x;
    brc_pkg::t_coord    out_src_max_y;

    modport source (
        output valid, visible, out_dst_x, out_dst_y,
               out_src_min_x, out_src_min_y, out_src_max_x, out_src_max_y,
        input  ready
    );
    modport sink (
        input  valid, visible, out_dst_x, out_dst_y,
               out_src_min_x, out_src_min_y, out_src_max_x, out_src_max_y,
        output ready
    );
endinterface

// Configuration register write channel.
interface brc_cfg_if;
    logic               valid;
    logic               ready;
    brc_pkg::t_reg_idx  index;
    brc_pkg::t_coord    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- design/blit_rect_clipper.sv -----
// Top level of the blit rectangle clipper: clip registers, input register and result register.
//
// Use: a blit request (destination corner and inclusive source rectangle) enters on i_req.
// It is clipped against the source and destination clip rectangles held in eight
// configuration registers written over i_cfg (index 0..7, always ready). One result per
// request leaves on o_res: visible and the clipped corner and source rectangle, or all
// coordinates zero when the blit is rejected.
// Path: a request accepted on i_req is held in the input register; the clip arithmetic sits
// between the input register and the result register, which presents the result on o_res.
// Throughput: one request per cycle, sustained, as long as o_res is taken every cycle.
// Stall: both registers hold their items while o_res.ready is low; i_req.ready falls only
// when both are full, so a request still enters while a finished result waits.
// Reset: i_rst_n (synchronous, active low) empties both registers and loads the clip
// rectangles with min edges at 0 and max edges at the largest positive coordinate.
// Configuration is to be written only while no request is in flight.
module blit_rect_clipper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brc_req_if.sink     i_req,
    brc_cfg_if.sink     i_cfg,
    brc_res_if.source   o_res
);

    // Clip rectangle registers.
    brc_pkg::t_coord r_cfg [brc_pkg::NUM_REGS];

    // Input register.
    logic            r_in_vld;
    brc_pkg::t_coord r_dst_x;
    brc_pkg::t_coord r_dst_y;
    brc_pkg::t_coord r_src_min_x;
    brc_pkg::t_coord r_src_min_y;
    brc_pkg::t_coord r_src_max_x;
    brc_pkg::t_coord r_src_max_y;

    // Result register.
    logic            r_out_vld;
    logic            r_visible;
    brc_pkg::t_coord r_out_dst_x;
    brc_pkg::t_coord r_out_dst_y;
    brc_pkg::t_coord r_out_src_min_x;
    brc_pkg::t_coord r_out_src_min_y;
    brc_pkg::t_coord r_out_src_max_x;
    brc_pkg::t_coord r_out_src_max_y;

    logic            out_load;
    logic            in_load;
    brc_pkg::t_axis  ax_x;
    brc_pkg::t_axis  ax_y;
    logic            n_visible;

    // Configuration writes are taken at any time.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[brc_pkg::REG_DEST_CLIP_MIN_X] <= brc_pkg::COORD_ZERO;
            r_cfg[brc_pkg::REG_DEST_CLIP_MIN_Y] <= brc_pkg::COORD_ZERO;
            r_cfg[brc_pkg::REG_DEST_CLIP_MAX_X] <= brc_pkg::COORD_MAX_POS;
            r_cfg[brc_pkg::REG_DEST_CLIP_MAX_Y] <= brc_pkg::COORD_MAX_POS;
            r_cfg[brc_pkg::REG_SRC_CLIP_MIN_X]  <= brc_pkg::COORD_ZERO;
            r_cfg[brc_pkg::REG_SRC_CLIP_MIN_Y]  <= brc_pkg::COORD_ZERO;
            r_cfg[brc_pkg::REG_SRC_CLIP_MAX_X]  <= brc_pkg::COORD_MAX_POS;
            r_cfg[brc_pkg::REG_SRC_CLIP_MAX_Y]  <= brc_pkg::COORD_MAX_POS;
        end else if (i_cfg.valid) begin
            r_cfg[i_cfg.index] <= i_cfg.data;
        end
    end

    // Handshake: the result register loads when empty or drained; the input register
    // loads when it is empty or its item moves on into the result register.
    assign out_load    = !r_out_vld || o_res.ready;
    assign in_load     = !r_in_vld || out_load;
    assign i_req.ready = in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_vld <= i_req.valid;
            end
            if (out_load) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (in_load && i_req.valid) begin
            r_dst_x     <= i_req.dst_x;
            r_dst_y     <= i_req.dst_y;
            r_src_min_x <= i_req.src_min_x;
            r_src_min_y <= i_req.src_min_y;
            r_src_max_x <= i_req.src_max_x;
            r_src_max_y <= i_req.src_max_y;
        end
    end

    // Clip each axis on its own; a blit is visible only if both axes survive.
    always_comb begin
        ax_x = brc_pkg::clip_axis(r_dst_x, r_src_min_x, r_src_max_x,
                                  r_cfg[brc_pkg::REG_SRC_CLIP_MIN_X],
                                  r_cfg[brc_pkg::REG_SRC_CLIP_MAX_X],
                                  r_cfg[brc_pkg::REG_DEST_CLIP_MIN_X],
                                  r_cfg[brc_pkg::REG_DEST_CLIP_MAX_X]);
        ax_y = brc_pkg::clip_axis(r_dst_y, r_src_min_y, r_src_max_y,
                                  r_cfg[brc_pkg::REG_SRC_CLIP_MIN_Y],
                                  r_cfg[brc_pkg::REG_SRC_CLIP_MAX_Y],
                                  r_cfg[brc_pkg::REG_DEST_CLIP_MIN_Y],
                                  r_cfg[brc_pkg::REG_DEST_CLIP_MAX_Y]);
        n_visible = ax_x.ok && ax_y.ok;
    end

    // Result register; a rejected blit reports all coordinates as zero.
    always_ff @(posedge i_clk) begin
        if (out_load && r_in_vld) begin
            r_visible       <= n_visible;
            r_out_dst_x     <= n_visible ? ax_x.d  : brc_pkg::COORD_ZERO;
            r_out_dst_y     <= n_visible ? ax_y.d  : brc_pkg::COORD_ZERO;
            r_out_src_min_x <= n_visible ? ax_x.s0 : brc_pkg::COORD_ZERO;
            r_out_src_min_y <= n_visible ? ax_y.s0 : brc_pkg::COORD_ZERO;
            r_out_src_max_x <= n_visible ? ax_x.s1 : brc_pkg::COORD_ZERO;
            r_out_src_max_y <= n_visible ? ax_y.s1 : brc_pkg::COORD_ZERO;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.visible       = r_visible;
    assign o_res.out_dst_x     = r_out_dst_x;
    assign o_res.out_dst_y     = r_out_dst_y;
    assign o_res.out_src_min_x = r_out_src_min_x;
    assign o_res.out_src_min_y = r_out_src_min_y;
    assign o_res.out_src_max_x = r_out_src_max_x;
    assign o_res.out_src_max_y = r_out_src_max_y;

endmodule
